// File: hdl/assert_macros.svh
// assertion macros used by the checker file of the chain code shape block
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, switched off while reset is high
`define CCSM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// concurrent check that also holds through reset
`define CCSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/ccsm_pkg.sv
// types, widths, chain code constants and helper functions of the chain code shape block
// no dependencies
`timescale 1ns / 1ps

package ccsm_pkg;

   localparam int COORD_W   = 12;
   localparam int DIR_W     = 3;
   localparam int SUM_W     = 27;
   localparam int SUMX_W    = SUM_W + 1;
   localparam int TERM_W    = 2 * COORD_W + 1;
   localparam int CTERM_W   = COORD_W + 3;
   localparam int CNT_W     = 13;
   localparam int CNT_FIELD_MAX = 8191;
   localparam int SCALE_W   = 16;
   localparam int PROD_P_W  = CNT_W + SCALE_W;
   localparam int PSUM_W    = PROD_P_W + 2;
   localparam int PERI_W    = 30;
   localparam int XY_W      = 2 * SCALE_W;
   localparam int MAG_W     = SUM_W;
   localparam int PROD_W    = MAG_W + XY_W;
   localparam int AREA_W    = PROD_W - 1;
   localparam int CSR_IDX_W = 2;
   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

   localparam logic [PERI_W-1:0]  PERI_MAX       = {PERI_W{1'b1}};
   localparam logic [SCALE_W-1:0] X_SCALE_RESET  = 16'd256;
   localparam logic [SCALE_W-1:0] Y_SCALE_RESET  = 16'd256;
   localparam logic [SCALE_W-1:0] DIAG_SCALE_RESET = 16'd362;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_X_SCALE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_SCALE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIAG_SCALE = 2'd2;

   // chain codes
   localparam logic [DIR_W-1:0] DIR_UL = 3'd0;
   localparam logic [DIR_W-1:0] DIR_U  = 3'd1;
   localparam logic [DIR_W-1:0] DIR_UR = 3'd2;
   localparam logic [DIR_W-1:0] DIR_R  = 3'd3;
   localparam logic [DIR_W-1:0] DIR_DR = 3'd4;
   localparam logic [DIR_W-1:0] DIR_D  = 3'd5;
   localparam logic [DIR_W-1:0] DIR_DL = 3'd6;
   localparam logic [DIR_W-1:0] DIR_L  = 3'd7;

   // one finished contour, handed from front to back
   typedef struct packed {
      logic signed [SUM_W-1:0]  chain;
      logic signed [SUM_W-1:0]  shoel;
      logic signed [TERM_W-1:0] close_term;
      logic [CNT_W-1:0]         horiz;
      logic [CNT_W-1:0]         vert;
      logic [CNT_W-1:0]         diag;
      logic                     sat;
   } contour_type;

   typedef struct packed {
      logic        push;
      contour_type entry;
   } push_type;

   // 2*y*dx + alfa for one step
   function automatic logic signed [CTERM_W-1:0] chain_term(input logic [DIR_W-1:0] dir,
                                                            input logic [COORD_W-1:0] y);
      logic signed [CTERM_W-1:0] y2;
      logic signed [CTERM_W-1:0] res;
      y2 = $signed({2'b00, y, 1'b0});
      case (dir)
         DIR_UL:  res = -y2 + CTERM_W'(1);
         DIR_U:   res = '0;
         DIR_UR:  res = y2 - CTERM_W'(1);
         DIR_R:   res = y2;
         DIR_DR:  res = y2 + CTERM_W'(1);
         DIR_D:   res = '0;
         DIR_DL:  res = -y2 - CTERM_W'(1);
         DIR_L:   res = -y2;
         default: res = '0;
      endcase
      return res;
   endfunction

   function automatic logic sum_ovf(input logic signed [SUMX_W-1:0] v);
      return v[SUMX_W-1] ^ v[SUMX_W-2];
   endfunction

   function automatic logic signed [SUM_W-1:0] clamp_sum(input logic signed [SUMX_W-1:0] v);
      logic signed [SUM_W-1:0] res;
      if (sum_ovf(v)) begin
         res = {v[SUMX_W-1], {(SUM_W-1){~v[SUMX_W-1]}}};
      end else begin
         res = v[SUM_W-1:0];
      end
      return res;
   endfunction

endpackage

// File: hdl/ccsm_front.sv
// front part: accepts boundary points, forms the per-point terms and keeps the running sums
// depends on ccsm_pkg
`timescale 1ns / 1ps

module ccsm_front #(
   parameter int MAX_POINTS = 4096,
   parameter int COORD_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [ccsm_pkg::COORD_W-1:0]     req_pos_x,
   input  logic [ccsm_pkg::COORD_W-1:0]     req_pos_y,
   input  logic [ccsm_pkg::DIR_W-1:0]       req_step_dir,
   input  logic                             req_is_last,
   input  logic [ccsm_pkg::Q_CNT_W-1:0]     q_count,
   output ccsm_pkg::push_type               q_push
);
   import ccsm_pkg::*;

   localparam logic [31:0] MaskWide = (32'd1 << COORD_BITS) - 32'd1;
   localparam logic [COORD_W-1:0] CoordMask = MaskWide[COORD_W-1:0];
   localparam int CapInt = (MAX_POINTS < CNT_FIELD_MAX) ? MAX_POINTS : CNT_FIELD_MAX;
   localparam logic [CNT_W-1:0] CountCap = CNT_W'(CapInt);

   logic                 accept;
   logic [COORD_W-1:0]   px, py, fx_sel, fy_sel;
   logic [2*COORD_W-1:0] pa, pb, pc, pd;

   // point tracking, updated on accept
   logic [COORD_W-1:0]   first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic [COORD_W-1:0]   prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                 awaiting_ff, awaiting_in;

   // stage a: one point with its terms
   logic                      a_valid_ff, a_valid_in;
   logic                      a_first_ff, a_first_in;
   logic                      a_last_ff, a_last_in;
   logic [DIR_W-1:0]          a_dir_ff, a_dir_in;
   logic signed [CTERM_W-1:0] a_cterm_ff, a_cterm_in;
   logic signed [TERM_W-1:0]  a_t1_ff, a_t1_in;
   logic signed [TERM_W-1:0]  a_tc_ff, a_tc_in;

   // running sums
   logic signed [SUM_W-1:0]  chain_ff, chain_in, shoel_ff, shoel_in;
   logic [CNT_W-1:0]         horiz_ff, horiz_in, vert_ff, vert_in, diag_ff, diag_in;
   logic                     sat_ff, sat_in;

   logic signed [SUMX_W-1:0] chain_sum, shoel_sum;
   logic signed [SUM_W-1:0]  chain_new, shoel_new;
   logic [CNT_W-1:0]         horiz_new, vert_new, diag_new;
   logic                     sat_new;
   logic [Q_CNT_W-1:0]       q_need;

   // a last point still in stage a takes a queue slot on the next edge
   assign q_need   = q_count + Q_CNT_W'(a_valid_ff && a_last_ff);
   assign req_full = (q_need >= Q_CNT_W'(Q_DEPTH));
   assign accept   = req_push && !req_full;

   always_comb begin
      px     = req_pos_x & CoordMask;
      py     = req_pos_y & CoordMask;
      fx_sel = awaiting_ff ? px : first_x_ff;
      fy_sel = awaiting_ff ? py : first_y_ff;
      pa     = prev_y_ff * px;
      pb     = prev_x_ff * py;
      pc     = py * fx_sel;
      pd     = px * fy_sel;

      a_valid_in = accept;
      a_first_in = awaiting_ff;
      a_last_in  = req_is_last;
      a_dir_in   = req_step_dir;
      a_cterm_in = chain_term(req_step_dir, py);
      a_t1_in    = $signed({1'b0, pa}) - $signed({1'b0, pb});
      a_tc_in    = $signed({1'b0, pc}) - $signed({1'b0, pd});

      first_x_in  = first_x_ff;
      first_y_in  = first_y_ff;
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      awaiting_in = awaiting_ff;
      if (accept) begin
         prev_x_in = px;
         prev_y_in = py;
         if (awaiting_ff) begin
            first_x_in = px;
            first_y_in = py;
         end
         awaiting_in = req_is_last;
      end
   end

   always_comb begin
      chain_sum = SUMX_W'(chain_ff) + SUMX_W'(a_cterm_ff);
      shoel_sum = SUMX_W'(shoel_ff) + SUMX_W'(a_t1_ff);
      sat_new   = sat_ff | sum_ovf(chain_sum);
      chain_new = clamp_sum(chain_sum);
      shoel_new = shoel_ff;
      if (!a_first_ff) begin
         shoel_new = clamp_sum(shoel_sum);
         sat_new   = sat_new | sum_ovf(shoel_sum);
      end

      horiz_new = horiz_ff;
      vert_new  = vert_ff;
      diag_new  = diag_ff;
      if (a_dir_ff == DIR_R || a_dir_ff == DIR_L) begin
         if (horiz_ff >= CountCap) begin
            horiz_new = CountCap;
            sat_new   = 1'b1;
         end else begin
            horiz_new = horiz_ff + CNT_W'(1);
         end
      end else if (a_dir_ff == DIR_U || a_dir_ff == DIR_D) begin
         if (vert_ff >= CountCap) begin
            vert_new = CountCap;
            sat_new  = 1'b1;
         end else begin
            vert_new = vert_ff + CNT_W'(1);
         end
      end else begin
         if (diag_ff >= CountCap) begin
            diag_new = CountCap;
            sat_new  = 1'b1;
         end else begin
            diag_new = diag_ff + CNT_W'(1);
         end
      end

      q_push.push             = a_valid_ff && a_last_ff;
      q_push.entry.chain      = chain_new;
      q_push.entry.shoel      = shoel_new;
      q_push.entry.close_term = a_tc_ff;
      q_push.entry.horiz      = horiz_new;
      q_push.entry.vert       = vert_new;
      q_push.entry.diag       = diag_new;
      q_push.entry.sat        = sat_new;

      chain_in = chain_ff;
      shoel_in = shoel_ff;
      horiz_in = horiz_ff;
      vert_in  = vert_ff;
      diag_in  = diag_ff;
      sat_in   = sat_ff;
      if (a_valid_ff) begin
         if (a_last_ff) begin
            // contour handed off, start clean
            chain_in = '0;
            shoel_in = '0;
            horiz_in = '0;
            vert_in  = '0;
            diag_in  = '0;
            sat_in   = 1'b0;
         end else begin
            chain_in = chain_new;
            shoel_in = shoel_new;
            horiz_in = horiz_new;
            vert_in  = vert_new;
            diag_in  = diag_new;
            sat_in   = sat_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_first_ff <= a_first_in;
      a_last_ff  <= a_last_in;
      a_dir_ff   <= a_dir_in;
      a_cterm_ff <= a_cterm_in;
      a_t1_ff    <= a_t1_in;
      a_tc_ff    <= a_tc_in;
      if (reset) begin
         a_valid_ff  <= 1'b0;
         awaiting_ff <= 1'b1;
         first_x_ff  <= '0;
         first_y_ff  <= '0;
         prev_x_ff   <= '0;
         prev_y_ff   <= '0;
         chain_ff    <= '0;
         shoel_ff    <= '0;
         horiz_ff    <= '0;
         vert_ff     <= '0;
         diag_ff     <= '0;
         sat_ff      <= 1'b0;
      end else begin
         a_valid_ff  <= a_valid_in;
         awaiting_ff <= awaiting_in;
         first_x_ff  <= first_x_in;
         first_y_ff  <= first_y_in;
         prev_x_ff   <= prev_x_in;
         prev_y_ff   <= prev_y_in;
         chain_ff    <= chain_in;
         shoel_ff    <= shoel_in;
         horiz_ff    <= horiz_in;
         vert_ff     <= vert_in;
         diag_ff     <= diag_in;
         sat_ff      <= sat_in;
      end
   end

endmodule

// File: hdl/ccsm_queue.sv
// short queue of finished contours between the front and the back part
// depends on ccsm_pkg
`timescale 1ns / 1ps

module ccsm_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  ccsm_pkg::push_type           q_push,
   input  logic                         q_pop,
   output ccsm_pkg::contour_type        q_head,
   output logic                         q_empty,
   output logic [ccsm_pkg::Q_CNT_W-1:0] q_count
);
   import ccsm_pkg::*;

   contour_type        mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               do_pop;

   assign q_head  = mem_ff[rd_ptr_ff];
   assign q_empty = (count_ff == '0);
   assign q_count = count_ff;
   assign do_pop  = q_pop && !q_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push.push) begin
         wr_ptr_in = wr_ptr_ff + Q_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + Q_PTR_W'(1);
      end
      if (q_push.push && !do_pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (!q_push.push && do_pop) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.push) begin
         mem_ff[wr_ptr_ff] <= q_push.entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hdl/ccsm_back.sv
// back part: calibration registers, closing term, perimeter and area scaling, result register
// depends on ccsm_pkg
`timescale 1ns / 1ps

module ccsm_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [ccsm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ccsm_pkg::SCALE_W-1:0]        csr_wdata,
   input  ccsm_pkg::contour_type               q_head,
   input  logic                                q_empty,
   output logic                                q_pop,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [ccsm_pkg::SUM_W-1:0]   rsp_chain_area_x2,
   output logic signed [ccsm_pkg::SUM_W-1:0]   rsp_shoelace_area_x2,
   output logic [ccsm_pkg::CNT_W-1:0]          rsp_horizontal_steps,
   output logic [ccsm_pkg::CNT_W-1:0]          rsp_vertical_steps,
   output logic [ccsm_pkg::CNT_W-1:0]          rsp_diagonal_steps,
   output logic [ccsm_pkg::PERI_W-1:0]         rsp_scaled_perimeter,
   output logic signed [ccsm_pkg::AREA_W-1:0]  rsp_scaled_area,
   output logic                                rsp_saturated
);
   import ccsm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLOSE,
      ST_ABS,
      ST_MUL,
      ST_RND,
      ST_OUT
   } state_type;

   state_type state_ff;

   logic [SCALE_W-1:0] x_scale_ff, y_scale_ff, diag_scale_ff;

   contour_type              e_ff;
   logic signed [SUM_W-1:0]  shoel_ff;
   logic                     sat_ff;
   logic [XY_W-1:0]          xy_ff;
   logic [PROD_P_W-1:0]      ph_ff, pv_ff, pd_ff;
   logic                     neg_ff;
   logic [MAG_W-1:0]         mag_ff;
   logic [PERI_W-1:0]        peri_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [AREA_W-1:0]        half_ff;
   logic                     out_valid_ff;

   logic signed [SUMX_W-1:0] close_sum;
   logic [PSUM_W-1:0]        psum;
   logic [PROD_W-1:0]        rnd;
   logic                     out_free;

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign rsp_empty = !out_valid_ff;
   assign out_free  = !out_valid_ff || rsp_pop;

   assign close_sum = SUMX_W'(e_ff.shoel) + SUMX_W'(e_ff.close_term);
   assign psum      = PSUM_W'(ph_ff) + PSUM_W'(pv_ff) + PSUM_W'(pd_ff);
   assign rnd       = prod_ff + PROD_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         x_scale_ff    <= X_SCALE_RESET;
         y_scale_ff    <= Y_SCALE_RESET;
         diag_scale_ff <= DIAG_SCALE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_X_SCALE:    x_scale_ff    <= csr_wdata;
            CSR_Y_SCALE:    y_scale_ff    <= csr_wdata;
            CSR_DIAG_SCALE: diag_scale_ff <= csr_wdata;
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         // a new word replaces the one popped in the same cycle
         if (state_ff == ST_OUT && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  e_ff     <= q_head;
                  state_ff <= ST_CLOSE;
               end
            end
            ST_CLOSE: begin
               // closing term back to the first point
               shoel_ff <= clamp_sum(close_sum);
               sat_ff   <= e_ff.sat | sum_ovf(close_sum);
               xy_ff    <= x_scale_ff * y_scale_ff;
               ph_ff    <= e_ff.horiz * x_scale_ff;
               pv_ff    <= e_ff.vert * y_scale_ff;
               pd_ff    <= e_ff.diag * diag_scale_ff;
               state_ff <= ST_ABS;
            end
            ST_ABS: begin
               neg_ff <= shoel_ff[SUM_W-1];
               mag_ff <= shoel_ff[SUM_W-1] ? MAG_W'(-shoel_ff) : MAG_W'(shoel_ff);
               if (psum > PSUM_W'(PERI_MAX)) begin
                  peri_ff <= PERI_MAX;
                  sat_ff  <= 1'b1;
               end else begin
                  peri_ff <= psum[PERI_W-1:0];
               end
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               prod_ff  <= mag_ff * xy_ff;
               state_ff <= ST_RND;
            end
            ST_RND: begin
               // halving rounds half away from zero on the magnitude
               half_ff  <= rnd[PROD_W-1:1];
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_chain_area_x2    <= e_ff.chain;
                  rsp_shoelace_area_x2 <= shoel_ff;
                  rsp_horizontal_steps <= e_ff.horiz;
                  rsp_vertical_steps   <= e_ff.vert;
                  rsp_diagonal_steps   <= e_ff.diag;
                  rsp_scaled_perimeter <= peri_ff;
                  rsp_scaled_area      <= neg_ff ? -$signed(half_ff) : $signed(half_ff);
                  rsp_saturated        <= sat_ff;
                  state_ff             <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// File: hdl/chain_code_shape_measures.sv
// top level of the chain code shape block: front, contour queue and back part
// depends on ccsm_pkg, ccsm_front, ccsm_queue, ccsm_back
`timescale 1ns / 1ps

// Usage:
// Boundary points of one contour are pushed on the req_ side, one word per point
// (pos_x, pos_y, step_dir, is_last); a word is taken when req_push is high and
// req_full is low. The front takes one point per cycle while req_full is low;
// per-point sums are updated in the cycle after the point is taken.
// One result word per contour appears on the rsp_ side after the last point:
// it is valid while rsp_empty is low and is taken with rsp_pop.
// After the last point is taken, the contour passes stage a and the queue; the
// back part then runs its close, abs, mul, rnd and out states and takes no new
// contour before it is back in idle. Up to 4 finished contours wait in the
// queue between front and back; req_full rises when it cannot take one more.
// When the receiver stalls, the result stays on the rsp_ ports, the back part
// holds its next result, the queue fills and then req_full holds off new points.
// Calibration registers are to be written through csr_ only while the block is
// idle; the block does not enforce it. Reset clears all sums, empties the queue
// and output, and loads the default calibration values.

module chain_code_shape_measures #(
   parameter int MAX_POINTS = 4096,
   parameter int COORD_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [ccsm_pkg::COORD_W-1:0]        req_pos_x,
   input  logic [ccsm_pkg::COORD_W-1:0]        req_pos_y,
   input  logic [ccsm_pkg::DIR_W-1:0]          req_step_dir,
   input  logic                                req_is_last,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [ccsm_pkg::SUM_W-1:0]   rsp_chain_area_x2,
   output logic signed [ccsm_pkg::SUM_W-1:0]   rsp_shoelace_area_x2,
   output logic [ccsm_pkg::CNT_W-1:0]          rsp_horizontal_steps,
   output logic [ccsm_pkg::CNT_W-1:0]          rsp_vertical_steps,
   output logic [ccsm_pkg::CNT_W-1:0]          rsp_diagonal_steps,
   output logic [ccsm_pkg::PERI_W-1:0]         rsp_scaled_perimeter,
   output logic signed [ccsm_pkg::AREA_W-1:0]  rsp_scaled_area,
   output logic                                rsp_saturated,
   input  logic                                csr_write_en,
   input  logic [ccsm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ccsm_pkg::SCALE_W-1:0]        csr_wdata
);
   import ccsm_pkg::*;

   push_type           q_push;
   contour_type        q_head;
   logic               q_empty;
   logic               q_pop;
   logic [Q_CNT_W-1:0] q_count;

   ccsm_front #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .req_step_dir (req_step_dir),
      .req_is_last  (req_is_last),
      .q_count      (q_count),
      .q_push       (q_push)
   );

   ccsm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .q_empty (q_empty),
      .q_count (q_count)
   );

   ccsm_back u_back (
      .clock                (clock),
      .reset                (reset),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .q_head               (q_head),
      .q_empty              (q_empty),
      .q_pop                (q_pop),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_chain_area_x2    (rsp_chain_area_x2),
      .rsp_shoelace_area_x2 (rsp_shoelace_area_x2),
      .rsp_horizontal_steps (rsp_horizontal_steps),
      .rsp_vertical_steps   (rsp_vertical_steps),
      .rsp_diagonal_steps   (rsp_diagonal_steps),
      .rsp_scaled_perimeter (rsp_scaled_perimeter),
      .rsp_scaled_area      (rsp_scaled_area),
      .rsp_saturated        (rsp_saturated)
   );

endmodule

// File: hdl/ccsm_checker.sv
// port level checks for the chain code shape block, attached to the top level by bind
// depends on ccsm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccsm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_full,
   input logic                                rsp_empty,
   input logic                                rsp_pop,
   input logic signed [ccsm_pkg::SUM_W-1:0]   rsp_shoelace_area_x2,
   input logic [ccsm_pkg::CNT_W-1:0]          rsp_horizontal_steps,
   input logic [ccsm_pkg::CNT_W-1:0]          rsp_vertical_steps,
   input logic [ccsm_pkg::CNT_W-1:0]          rsp_diagonal_steps,
   input logic signed [ccsm_pkg::AREA_W-1:0]  rsp_scaled_area,
   input logic                                rsp_saturated
);

   `CCSM_ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> rsp_empty, "result after reset")

   `CCSM_ASSERT_ALWAYS(a_ready_after_reset, clock, reset |=> !req_full, "full after reset")

   `CCSM_ASSERT(a_word_holds, clock, reset, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_scaled_area) && $stable(rsp_saturated), "result word changed while stalled")

   // every contour has at least one point, so some step count is nonzero
   `CCSM_ASSERT(a_steps_present, clock, reset, !rsp_empty |-> (rsp_horizontal_steps != '0 || rsp_vertical_steps != '0 || rsp_diagonal_steps != '0), "result with no steps")

   `CCSM_ASSERT(a_zero_area, clock, reset, !rsp_empty && rsp_shoelace_area_x2 == '0 |-> rsp_scaled_area == '0, "nonzero area from zero shoelace sum")

endmodule

bind chain_code_shape_measures ccsm_checker u_checker (.*);

// File: sim/chain_code_shape_measures_tb.sv
// self-checking testbench for chain_code_shape_measures
// boundary points in, one checked word per contour out; depends on ccsm_pkg and the top level
`timescale 1ns / 1ps

module chain_code_shape_measures_tb;
   import ccsm_pkg::*;

   localparam int MAX_POINTS = 4096;
   localparam int COUNT_CAP = (MAX_POINTS < CNT_FIELD_MAX) ? MAX_POINTS : CNT_FIELD_MAX;
   localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
   localparam longint SUM_LO = -(longint'(1) <<< (SUM_W - 1));
   localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};
   localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};
   localparam logic [CSR_IDX_W-1:0] CSR_NONE = 2'd3;
   localparam int RANDOM_POINTS = 1750;
   localparam int DRAIN_CYCLES = 12;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int STALL_CYCLES = 400;

   typedef struct {
      logic signed [SUM_W-1:0]  chain_area;
      logic signed [SUM_W-1:0]  shoelace_area;
      logic [CNT_W-1:0]         horiz;
      logic [CNT_W-1:0]         vert;
      logic [CNT_W-1:0]         diag;
      logic [PERI_W-1:0]        perimeter;
      logic signed [AREA_W-1:0] area;
      logic                     saturated;
   } shape_measures_type;

   logic                        clock;
   logic                        reset;
   logic                        req_push;
   logic                        req_full;
   logic [COORD_W-1:0]          req_pos_x;
   logic [COORD_W-1:0]          req_pos_y;
   logic [DIR_W-1:0]            req_step_dir;
   logic                        req_is_last;
   logic                        rsp_empty;
   logic                        rsp_pop;
   logic signed [SUM_W-1:0]     rsp_chain_area_x2;
   logic signed [SUM_W-1:0]     rsp_shoelace_area_x2;
   logic [CNT_W-1:0]            rsp_horizontal_steps;
   logic [CNT_W-1:0]            rsp_vertical_steps;
   logic [CNT_W-1:0]            rsp_diagonal_steps;
   logic [PERI_W-1:0]           rsp_scaled_perimeter;
   logic signed [AREA_W-1:0]    rsp_scaled_area;
   logic                        rsp_saturated;
   logic                        csr_write_en;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [SCALE_W-1:0]          csr_wdata;

   // contour tracker state and calibration copy
   longint             acc_chain;
   longint             acc_shoel;
   logic [COORD_W-1:0] start_x;
   logic [COORD_W-1:0] start_y;
   logic [COORD_W-1:0] last_x;
   logic [COORD_W-1:0] last_y;
   int                 cnt_h;
   int                 cnt_v;
   int                 cnt_d;
   bit                 at_start;
   bit                 clamp_seen;
   logic [SCALE_W-1:0] cfg_x;
   logic [SCALE_W-1:0] cfg_y;
   logic [SCALE_W-1:0] cfg_diag;

   shape_measures_type expected_shapes[$];

   int  mismatches;
   int  points_sent;
   int  contours_sent;
   int  results_checked;
   int  stall_left;
   int  quiet_cycles;
   bit  no_idle;

   chain_code_shape_measures dut (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_step_dir         (req_step_dir),
      .req_is_last          (req_is_last),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_chain_area_x2    (rsp_chain_area_x2),
      .rsp_shoelace_area_x2 (rsp_shoelace_area_x2),
      .rsp_horizontal_steps (rsp_horizontal_steps),
      .rsp_vertical_steps   (rsp_vertical_steps),
      .rsp_diagonal_steps   (rsp_diagonal_steps),
      .rsp_scaled_perimeter (rsp_scaled_perimeter),
      .rsp_scaled_area      (rsp_scaled_area),
      .rsp_saturated        (rsp_saturated),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return COORD_MAX;
         default: return COORD_W'($urandom_range(0, COORD_MAX));
      endcase
   endfunction

   function automatic logic [SCALE_W-1:0] pick_scale();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return SCALE_MAX;
         2: return SCALE_W'($urandom_range(200, 400));
         default: return SCALE_W'($urandom_range(0, SCALE_MAX));
      endcase
   endfunction

   function automatic int step_dx(input logic [DIR_W-1:0] dir);
      case (dir)
         DIR_UL, DIR_DL, DIR_L: return -1;
         DIR_U, DIR_D:          return 0;
         default:               return 1;
      endcase
   endfunction

   function automatic int step_dy(input logic [DIR_W-1:0] dir);
      case (dir)
         DIR_UL, DIR_U, DIR_UR: return 1;
         DIR_DR, DIR_D, DIR_DL: return -1;
         default:               return 0;
      endcase
   endfunction

   function automatic longint clamp_acc(input longint v);
      if (v > SUM_HI) begin
         clamp_seen = 1'b1;
         return SUM_HI;
      end
      if (v < SUM_LO) begin
         clamp_seen = 1'b1;
         return SUM_LO;
      end
      return v;
   endfunction

   function automatic int bump_count(input int c);
      if (c >= COUNT_CAP) begin
         clamp_seen = 1'b1;
         return COUNT_CAP;
      end
      return c + 1;
   endfunction

   task automatic restart_contour();
      acc_chain = 0;
      acc_shoel = 0;
      start_x = '0;
      start_y = '0;
      last_x = '0;
      last_y = '0;
      cnt_h = 0;
      cnt_v = 0;
      cnt_d = 0;
      at_start = 1'b1;
      clamp_seen = 1'b0;
   endtask

   // updates the tracker with one accepted point, queues a word on the last one
   task automatic track_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [DIR_W-1:0] dir, input logic last);
      longint xv, yv, px, py, fx, fy, alfa;
      longint unsigned hv, vv, dv, sxv, syv, sdv, peri, mag, half;
      longint area_v;
      bit neg;
      shape_measures_type r;
      xv = x;
      yv = y;
      px = last_x;
      py = last_y;
      case (dir)
         DIR_UL, DIR_DR: alfa = 1;
         DIR_UR, DIR_DL: alfa = -1;
         default:        alfa = 0;
      endcase
      acc_chain = clamp_acc(acc_chain + 2 * yv * step_dx(dir) + alfa);
      if (at_start) begin
         start_x = x;
         start_y = y;
         at_start = 1'b0;
      end else begin
         acc_shoel = clamp_acc(acc_shoel + py * xv - px * yv);
      end
      last_x = x;
      last_y = y;
      case (dir)
         DIR_R, DIR_L: cnt_h = bump_count(cnt_h);
         DIR_U, DIR_D: cnt_v = bump_count(cnt_v);
         default:      cnt_d = bump_count(cnt_d);
      endcase
      if (last) begin
         // close the polygon back to the first point
         fx = start_x;
         fy = start_y;
         acc_shoel = clamp_acc(acc_shoel + yv * fx - xv * fy);
         hv = cnt_h;
         vv = cnt_v;
         dv = cnt_d;
         sxv = cfg_x;
         syv = cfg_y;
         sdv = cfg_diag;
         peri = hv * sxv + vv * syv + dv * sdv;
         if (peri > PERI_MAX) begin
            peri = PERI_MAX;
            clamp_seen = 1'b1;
         end
         neg = acc_shoel < 0;
         mag = neg ? -acc_shoel : acc_shoel;
         mag = mag * (sxv * syv);
         // halving rounds half away from zero
         half = (mag + 1) >> 1;
         area_v = neg ? -$signed(half) : $signed(half);
         r.chain_area = SUM_W'(acc_chain);
         r.shoelace_area = SUM_W'(acc_shoel);
         r.horiz = CNT_W'(cnt_h);
         r.vert = CNT_W'(cnt_v);
         r.diag = CNT_W'(cnt_d);
         r.perimeter = PERI_W'(peri);
         r.area = AREA_W'(area_v);
         r.saturated = clamp_seen;
         expected_shapes.push_back(r);
         restart_contour();
      end
   endtask

   task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [DIR_W-1:0] dir, input logic last);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_pos_x <= x;
      req_pos_y <= y;
      req_step_dir <= dir;
      req_is_last <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      track_point(x, y, dir, last);
      points_sent++;
      if (last) contours_sent++;
   endtask

   // stops the sender and waits until every expected word has come out
   task automatic drain();
      @(negedge clock);
      req_push <= 1'b0;
      while (expected_shapes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_scale(input logic [CSR_IDX_W-1:0] idx, input logic [SCALE_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_X_SCALE:    cfg_x = value;
         CSR_Y_SCALE:    cfg_y = value;
         CSR_DIAG_SCALE: cfg_diag = value;
         default: ;
      endcase
   endtask

   task automatic send_random_contour(input int len, input bit walk);
      logic [COORD_W-1:0] x, y;
      logic [DIR_W-1:0] dir;
      x = pick_coord();
      y = pick_coord();
      for (int i = 0; i < len; i++) begin
         dir = DIR_W'($urandom);
         send_point(x, y, dir, i == len - 1);
         if (walk) begin
            x = COORD_W'(x + step_dx(dir));
            y = COORD_W'(y + step_dy(dir));
         end else begin
            x = pick_coord();
            y = pick_coord();
         end
      end
   endtask

   task automatic test_directed();
      // one-point contours at both coordinate extremes
      send_point(COORD_MAX, COORD_MAX, DIR_UL, 1'b1);
      send_point('0, '0, DIR_L, 1'b1);
      // every chain code once
      send_point('0, '0, DIR_UL, 1'b0);
      send_point(COORD_MAX, '0, DIR_U, 1'b0);
      send_point(COORD_MAX, COORD_MAX, DIR_UR, 1'b0);
      send_point('0, COORD_MAX, DIR_R, 1'b0);
      send_point(12'd2048, 12'd1, DIR_DR, 1'b0);
      send_point(12'd1, 12'd2048, DIR_DL, 1'b0);
      send_point(COORD_MAX, COORD_MAX, DIR_D, 1'b0);
      send_point('0, '0, DIR_L, 1'b1);
      // unit square traced counterclockwise
      send_point(12'd10, 12'd10, DIR_R, 1'b0);
      send_point(12'd11, 12'd10, DIR_U, 1'b0);
      send_point(12'd11, 12'd11, DIR_L, 1'b0);
      send_point(12'd10, 12'd11, DIR_D, 1'b1);
   endtask

   task automatic test_calibration();
      logic [SCALE_W-1:0] sx[6] = '{16'd0, 16'hFFFF, 16'd1, 16'd0, X_SCALE_RESET, 16'hFFFF};
      logic [SCALE_W-1:0] sy[6] = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, Y_SCALE_RESET, 16'hFFFF};
      logic [SCALE_W-1:0] sd[6] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd1, DIAG_SCALE_RESET, 16'hFFFF};
      for (int p = 0; p < 6; p++) begin
         drain();
         write_scale(CSR_X_SCALE, sx[p]);
         write_scale(CSR_Y_SCALE, sy[p]);
         write_scale(CSR_DIAG_SCALE, sd[p]);
         // an unmapped index must leave the scales alone
         if (p == 2) write_scale(CSR_NONE, pick_scale());
         repeat (3) send_random_contour($urandom_range(1, 6), 1'b1);
      end
   endtask

   // full-size square wound twice, then three times, each way round; three windings run the shoelace sum past both ends
   task automatic test_shoelace_clamp();
      for (int loops = 2; loops <= 3; loops++) begin
         for (int i = 0; i < loops; i++) begin
            send_point('0, COORD_MAX, DIR_R, 1'b0);
            send_point(COORD_MAX, COORD_MAX, DIR_D, 1'b0);
            send_point(COORD_MAX, '0, DIR_L, 1'b0);
            send_point('0, '0, DIR_U, i == loops - 1);
         end
         for (int i = 0; i < loops; i++) begin
            send_point('0, '0, DIR_R, 1'b0);
            send_point(COORD_MAX, '0, DIR_U, 1'b0);
            send_point(COORD_MAX, COORD_MAX, DIR_L, 1'b0);
            send_point('0, COORD_MAX, DIR_D, i == loops - 1);
         end
      end
   endtask

   task automatic test_back_pressure();
      stall_left = STALL_CYCLES;
      no_idle = 1'b1;
      repeat (40) send_random_contour(2, 1'b1);
      no_idle = 1'b0;
   endtask

   task automatic test_random_contours();
      int sent, next_cfg, r, len;
      sent = 0;
      next_cfg = 250;
      while (sent < RANDOM_POINTS) begin
         if (sent >= next_cfg) begin
            drain();
            write_scale(CSR_X_SCALE, pick_scale());
            write_scale(CSR_Y_SCALE, pick_scale());
            write_scale(CSR_DIAG_SCALE, pick_scale());
            no_idle = ($urandom_range(0, 3) == 0);
            next_cfg += 250;
         end
         r = $urandom_range(0, 99);
         if (r < 10) len = 1;
         else if (r < 85) len = $urandom_range(2, 12);
         else len = $urandom_range(13, 60);
         // mostly traced walks, the rest scattered points
         send_random_contour(len, $urandom_range(0, 4) != 0);
         sent += len;
      end
      no_idle = 1'b0;
   endtask

   initial begin : pop_driver
      int pop_wait;
      pop_wait = 0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_pop <= 1'b0;
            stall_left--;
         end else if (pop_wait > 0) begin
            rsp_pop <= 1'b0;
            pop_wait--;
         end else begin
            rsp_pop <= 1'b1;
            pop_wait = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : check_results
      shape_measures_type want;
      shape_measures_type got;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.chain_area = rsp_chain_area_x2;
         got.shoelace_area = rsp_shoelace_area_x2;
         got.horiz = rsp_horizontal_steps;
         got.vert = rsp_vertical_steps;
         got.diag = rsp_diagonal_steps;
         got.perimeter = rsp_scaled_perimeter;
         got.area = rsp_scaled_area;
         got.saturated = rsp_saturated;
         results_checked++;
         if (expected_shapes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word at %0t ns", $time);
         end else begin
            want = expected_shapes.pop_front();
            if (got.chain_area !== want.chain_area || got.shoelace_area !== want.shoelace_area ||
                got.horiz !== want.horiz || got.vert !== want.vert ||
                got.diag !== want.diag || got.perimeter !== want.perimeter ||
                got.area !== want.area || got.saturated !== want.saturated) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("bad word at %0t ns (expected/actual): chain %0d/%0d shoelace %0d/%0d",
                           $time, want.chain_area, got.chain_area,
                           want.shoelace_area, got.shoelace_area);
                  $display("   steps h %0d/%0d v %0d/%0d d %0d/%0d perimeter %0d/%0d",
                           want.horiz, got.horiz, want.vert, got.vert,
                           want.diag, got.diag, want.perimeter, got.perimeter);
                  $display("   area %0d/%0d saturated %0b/%0b",
                           want.area, got.area, want.saturated, got.saturated);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_write_en) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles, %0d words outstanding",
                  quiet_cycles, expected_shapes.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_step_dir = DIR_UL;
      req_is_last = 1'b0;
      csr_write_en = 1'b0;
      csr_index = CSR_X_SCALE;
      csr_wdata = '0;
      mismatches = 0;
      points_sent = 0;
      contours_sent = 0;
      results_checked = 0;
      stall_left = 0;
      quiet_cycles = 0;
      no_idle = 1'b0;
      cfg_x = X_SCALE_RESET;
      cfg_y = Y_SCALE_RESET;
      cfg_diag = DIAG_SCALE_RESET;
      restart_contour();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_calibration();
      test_shoelace_clamp();
      test_back_pressure();
      test_random_contours();
      drain();

      $display("sent %0d points in %0d contours, checked %0d result words",
               points_sent, contours_sent, results_checked);
      $display("run included extreme scales, shoelace clamps at both ends and a full-queue stall");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
